@@ hw/rtl/blrt_pkg.sv @@
package blrt_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    // address of a row, count of rows (0 .. MAX_ROWS), count of columns (0 .. MAX_COLS)
    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROW_CW = $clog2(MAX_ROWS + 1);
    localparam int COL_CW = $clog2(MAX_COLS + 1);
    localparam int RUN_W  = COL_CW;

    localparam int CFG_W = 7;
    localparam int IDX_W = 6;
    localparam int OUT_W = 7;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_TOGGLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_SCAN_COL,
        ST_WRITE_RUN,
        ST_SCAN_ROW,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic load;
        logic cell_rd;
        logic cell_wr;
        logic col_step;
        logic run_wr;
        logic row_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic oor_in;
        logic op_toggle;
        logic col_last;
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

@@ hw/rtl/blrt_ram.sv @@
module blrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/blrt_ctrl.sv @@
module blrt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  blrt_pkg::status_t  status,
    output blrt_pkg::cmd_t     cmd
);

    blrt_pkg::state_t state_reg;
    blrt_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= blrt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            blrt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = status.oor_in ? blrt_pkg::ST_SCAN_ROW : blrt_pkg::ST_READ;
                end
            end
            blrt_pkg::ST_READ: begin
                cmd.cell_rd = 1'b1;
                state_next  = blrt_pkg::ST_MODIFY;
            end
            blrt_pkg::ST_MODIFY: begin
                cmd.cell_wr = 1'b1;
                state_next  = blrt_pkg::ST_SCAN_COL;
            end
            blrt_pkg::ST_SCAN_COL: begin
                cmd.col_step = 1'b1;
                if (status.col_last) begin
                    state_next = blrt_pkg::ST_WRITE_RUN;
                end
            end
            blrt_pkg::ST_WRITE_RUN: begin
                cmd.run_wr = 1'b1;
                state_next = status.op_toggle ? blrt_pkg::ST_SCAN_ROW : blrt_pkg::ST_IDLE;
            end
            blrt_pkg::ST_SCAN_ROW: begin
                // keep stepping until the last read has been folded in
                cmd.row_step = 1'b1;
                if (status.scan_done) begin
                    state_next = blrt_pkg::ST_OUTPUT;
                end
            end
            blrt_pkg::ST_OUTPUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = blrt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = blrt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/blrt_datapath.sv @@
module blrt_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  blrt_pkg::cmd_t                  cmd,
    output blrt_pkg::status_t               status,
    input  logic                            in_op,
    input  logic [blrt_pkg::IDX_W-1:0]      in_row,
    input  logic [blrt_pkg::IDX_W-1:0]      in_col,
    input  logic                            in_val,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [blrt_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            m_tready,
    output logic                            out_valid,
    output logic [blrt_pkg::OUT_W-1:0]      out_run,
    output logic                            out_oor
);

    localparam int ROWS   = blrt_pkg::MAX_ROWS;
    localparam int COLS   = blrt_pkg::MAX_COLS;
    localparam int ROW_AW = blrt_pkg::ROW_AW;
    localparam int ROW_CW = blrt_pkg::ROW_CW;
    localparam int COL_CW = blrt_pkg::COL_CW;
    localparam int RUN_W  = blrt_pkg::RUN_W;

    // control state
    logic [blrt_pkg::CFG_W-1:0] rows_cfg_reg;
    logic [blrt_pkg::CFG_W-1:0] cols_cfg_reg;
    logic [ROWS-1:0]            cell_vld_reg;
    logic [ROWS-1:0]            run_vld_reg;
    logic                       pend_reg;
    logic                       out_valid_reg;

    // payload
    logic                       op_reg;
    logic [blrt_pkg::IDX_W-1:0] row_reg;
    logic [blrt_pkg::IDX_W-1:0] col_reg;
    logic                       val_reg;
    logic                       oor_reg;
    logic [COLS-1:0]            shift_reg;
    logic [COL_CW-1:0]          col_cnt_reg;
    logic [RUN_W-1:0]           cur_reg;
    logic [RUN_W-1:0]           best_reg;
    logic [ROW_CW-1:0]          row_cnt_reg;
    logic                       pend_vld_reg;
    logic [RUN_W-1:0]           max_reg;
    logic [RUN_W-1:0]           out_run_reg;
    logic                       out_oor_reg;

    logic [ROW_CW-1:0]          eff_rows;
    logic [COL_CW-1:0]          eff_cols;
    logic [ROW_AW-1:0]          row_addr;
    logic [ROW_AW-1:0]          scan_addr;
    logic                       row_active;
    logic [COLS-1:0]            cell_rdata;
    logic [COLS-1:0]            cell_cur;
    logic [COLS-1:0]            col_mask;
    logic [COLS-1:0]            cell_new;
    logic [RUN_W-1:0]           run_rdata;
    logic [RUN_W-1:0]           cur_next;
    logic [RUN_W-1:0]           best_next;
    logic                       out_free;

    assign eff_rows = (int'(rows_cfg_reg) > ROWS) ? ROW_CW'(ROWS) : ROW_CW'(rows_cfg_reg);
    assign eff_cols = (int'(cols_cfg_reg) > COLS) ? COL_CW'(COLS) : COL_CW'(cols_cfg_reg);

    assign row_addr   = ROW_AW'(row_reg);
    assign scan_addr  = row_cnt_reg[ROW_AW-1:0];
    assign row_active = row_cnt_reg < eff_rows;

    // unwritten rows read as all zeros
    assign cell_cur = cell_vld_reg[row_addr] ? cell_rdata : '0;
    assign col_mask = COLS'(1) << col_reg;
    always_comb begin
        if (op_reg == blrt_pkg::OP_TOGGLE) begin
            cell_new = cell_cur ^ col_mask;
        end else if (val_reg) begin
            cell_new = cell_cur | col_mask;
        end else begin
            cell_new = cell_cur & ~col_mask;
        end
    end

    assign cur_next  = shift_reg[0] ? cur_reg + RUN_W'(1) : '0;
    assign best_next = (cur_next > best_reg) ? cur_next : best_reg;

    assign out_free = !out_valid_reg || m_tready;

    assign status.oor_in    = (int'(in_row) >= int'(eff_rows)) || (int'(in_col) >= int'(eff_cols));
    assign status.op_toggle = op_reg == blrt_pkg::OP_TOGGLE;
    assign status.col_last  = col_cnt_reg == (eff_cols - COL_CW'(1));
    assign status.scan_done = !row_active && !pend_reg;
    assign status.out_free  = out_free;

    blrt_ram #(
        .WIDTH (COLS),
        .DEPTH (ROWS)
    ) u_cell_ram (
        .aclk  (aclk),
        .we    (cmd.cell_wr),
        .waddr (row_addr),
        .wdata (cell_new),
        .re    (cmd.cell_rd),
        .raddr (row_addr),
        .rdata (cell_rdata)
    );

    blrt_ram #(
        .WIDTH (RUN_W),
        .DEPTH (ROWS)
    ) u_run_ram (
        .aclk  (aclk),
        .we    (cmd.run_wr),
        .waddr (row_addr),
        .wdata (best_reg),
        .re    (cmd.row_step && row_active),
        .raddr (scan_addr),
        .rdata (run_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg  <= blrt_pkg::CFG_W'(64);
            cols_cfg_reg  <= blrt_pkg::CFG_W'(64);
            cell_vld_reg  <= '0;
            run_vld_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    blrt_pkg::REG_ROWS: rows_cfg_reg <= cfg_wdata;
                    blrt_pkg::REG_COLS: cols_cfg_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.cell_wr) begin
                cell_vld_reg[row_addr] <= 1'b1;
            end
            if (cmd.run_wr) begin
                run_vld_reg[row_addr] <= 1'b1;
            end
            if (cmd.load) begin
                pend_reg <= 1'b0;
            end else if (cmd.row_step) begin
                pend_reg <= row_active;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= in_op;
            row_reg     <= in_row;
            col_reg     <= in_col;
            val_reg     <= in_val;
            oor_reg     <= status.oor_in;
            row_cnt_reg <= '0;
            max_reg     <= '0;
        end
        if (cmd.cell_wr) begin
            shift_reg   <= cell_new;
            col_cnt_reg <= '0;
            cur_reg     <= '0;
            best_reg    <= '0;
        end
        if (cmd.col_step) begin
            shift_reg   <= shift_reg >> 1;
            col_cnt_reg <= col_cnt_reg + COL_CW'(1);
            cur_reg     <= cur_next;
            best_reg    <= best_next;
        end
        if (cmd.row_step) begin
            // fold the entry read last cycle, then issue the next read
            if (pend_reg && pend_vld_reg && (run_rdata > max_reg)) begin
                max_reg <= run_rdata;
            end
            if (row_active) begin
                pend_vld_reg <= run_vld_reg[scan_addr];
                row_cnt_reg  <= row_cnt_reg + ROW_CW'(1);
            end
        end
        if (cmd.out_load) begin
            out_run_reg <= max_reg;
            out_oor_reg <= oor_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_run   = blrt_pkg::OUT_W'(out_run_reg);
    assign out_oor   = out_oor_reg;

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result loaded over an untaken beat");

    a_cell_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cell_wr |=> cell_vld_reg[row_addr])
        else $error("written row not marked valid");

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.col_step |-> (col_cnt_reg < eff_cols))
        else $error("column scan past the columns in use");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !pend_reg || !cmd.row_step)
        else $error("row scan active while a new item loads");

endmodule

@@ hw/rtl/bitmap_longest_run_tracker.sv @@
// Bit matrix of up to 64 x 64 cells with a longest-run-of-ones figure per row.
// Input channel (s_*): one beat is one item. s_tuser carries op (write or
// toggle), s_tdata carries row_index, col_index and cell_value.
// Result channel (m_*): one beat per toggle and per out-of-range item;
// m_tdata carries best_run, m_tuser carries out_of_range. In-range writes
// give no beat.
// Config port: cfg_wr_en with cfg_index 0 (rows_in_use) or 1 (cols_in_use)
// writes cfg_wdata at the clock edge; write only while the block is idle.
// Flow: an item runs to completion before the next is taken. An in-range
// item reads its row, writes it back, scans its columns and writes the row's
// run; a toggle then scans the rows in use for its result beat, and an
// out-of-range item goes straight to that row scan. The column scan walks
// one bit a cycle through a shift register, and the row scan reads the run
// memory one row a cycle.
// Reset (aresetn low, synchronous) empties the matrix and all row runs at
// once through per-row valid bits, and sets both sizes to 64.
// When the receiver stalls, the result waits in the output register; the
// block still takes the next item and stops only when its own result is due.
module bitmap_longest_run_tracker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] row_index, [11:6] col_index, [12] cell_value
    input  logic [0:0]  s_tuser,   // [0] op

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] best_run
    output logic [0:0]  m_tuser,   // [0] out_of_range

    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata
);

    blrt_pkg::cmd_t    cmd;
    blrt_pkg::status_t status;
    logic [blrt_pkg::OUT_W-1:0] best_run;
    logic                       out_of_range;

    blrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    blrt_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_op     (s_tuser[0]),
        .in_row    (s_tdata[5:0]),
        .in_col    (s_tdata[11:6]),
        .in_val    (s_tdata[12]),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .out_valid (m_tvalid),
        .out_run   (best_run),
        .out_oor   (out_of_range)
    );

    assign m_tdata = {1'b0, best_run};
    assign m_tuser = out_of_range;

endmodule
